### rtl/generational_handle_slot_pool_defines.svh
// Assertion macros shared by the handle slot pool RTL.
`ifndef GENERATIONAL_HANDLE_SLOT_POOL_DEFINES_SVH
`define GENERATIONAL_HANDLE_SLOT_POOL_DEFINES_SVH

`ifndef SYNTHESIS
// Implication or plain property that must hold at every clock edge out of reset.
`define GHSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be seen at a clock edge out of reset.
`define GHSP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define GHSP_ASSERT(label, clk, rst, prop, msg)
`define GHSP_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

### rtl/ghsp_pkg.sv
// Types and constants shared by the handle slot pool modules.
package ghsp_pkg;

   localparam int SLOT_COUNT  = 256;
   localparam int GEN_BITS    = 16;
   localparam int INDEX_BITS  = $clog2(SLOT_COUNT);
   localparam int COUNT_BITS  = $clog2(SLOT_COUNT + 1);
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;

   // The free-slot search is split into groups so that each stage stays small.
   localparam int GROUP_SIZE  = (SLOT_COUNT < 16) ? SLOT_COUNT : 16;
   localparam int GROUP_COUNT = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int MAP_BITS    = GROUP_COUNT * GROUP_SIZE;
   localparam int OFFSET_BITS = $clog2(GROUP_SIZE);

   localparam logic [CMD_BITS-1:0] CMD_ALLOC  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_FREE   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_STALE = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic                  valid;
      logic                  free_bit;
      logic [INDEX_BITS-1:0] index;
   } map_update_type;

   typedef struct packed {
      logic                  found;
      logic [INDEX_BITS-1:0] index;
   } search_result_type;

endpackage

### rtl/generational_handle_slot_pool.sv
// Generational handle slot pool: top level with control, counters and result register.
// Allocate goes through the search and update states, free and lookup through update only,
// and no new request is taken until the pool is back in idle, because of the registered
// free-slot search and the read-modify-write of the generation memory.
// Reset is synchronous and clears the state machine, high-water mark, live count and
// result valid.
`include "generational_handle_slot_pool_defines.svh"

module generational_handle_slot_pool (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ghsp_pkg::CMD_BITS-1:0]        req_cmd,
   input  logic [ghsp_pkg::INDEX_BITS-1:0]      req_handle_index,
   input  logic [ghsp_pkg::GEN_BITS-1:0]        req_handle_generation,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ghsp_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [ghsp_pkg::INDEX_BITS-1:0]      rsp_out_index,
   output logic [ghsp_pkg::GEN_BITS-1:0]        rsp_out_generation,
   output logic [ghsp_pkg::COUNT_BITS-1:0]      rsp_live_count
);
   import ghsp_pkg::*;

   // Control state and the latched request.
   state_type               state_ff, state_in;
   logic [CMD_BITS-1:0]     cmd_ff, cmd_in;
   logic [INDEX_BITS-1:0]   idx_ff, idx_in;
   logic [GEN_BITS-1:0]     gen_ff, gen_in;
   logic [COUNT_BITS-1:0]   hw_ff, hw_in;
   logic [COUNT_BITS-1:0]   live_ff, live_in;
   logic                    alloc_found_ff, alloc_found_in;
   logic [INDEX_BITS-1:0]   alloc_slot_ff, alloc_slot_in;

   // Result register, which lets a new request in while a result waits.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [INDEX_BITS-1:0]   rsp_index_ff, rsp_index_in;
   logic [GEN_BITS-1:0]     rsp_gen_ff, rsp_gen_in;
   logic [COUNT_BITS-1:0]   rsp_live_ff, rsp_live_in;

   // Generation memory and free map connections.
   logic                    rd_en;
   logic [INDEX_BITS-1:0]   rd_addr;
   logic [GEN_BITS-1:0]     rd_data;
   logic                    wr_en;
   logic [INDEX_BITS-1:0]   wr_addr;
   logic [GEN_BITS-1:0]     wr_data;
   logic                    snap;
   map_update_type          map_update;
   logic                    probe_free;
   search_result_type       search;

   // Handle check terms, valid in the update state.
   logic                    range_ok;
   logic                    gen_match;

   ghsp_gen_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (GEN_BITS)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ghsp_free_map u_free_map (
      .clock       (clock),
      .high_water  (hw_ff),
      .snap        (snap),
      .update      (map_update),
      .probe_index (idx_ff),
      .probe_free  (probe_free),
      .search      (search)
   );

   // A handle is good only when its index lies below the high-water mark and the slot is
   // live with the same generation. Entries above the mark are never looked at.
   assign range_ok  = COUNT_BITS'(idx_ff) < hw_ff;
   assign gen_match = !probe_free && (rd_data == gen_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hw_ff        <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hw_ff        <= hw_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      idx_ff         <= idx_in;
      gen_ff         <= gen_in;
      alloc_found_ff <= alloc_found_in;
      alloc_slot_ff  <= alloc_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_gen_ff     <= rsp_gen_in;
      rsp_live_ff    <= rsp_live_in;
   end

   // The idle state takes a request and starts the memory read with the handle index.
   // Allocate then picks the lowest free slot in the search state and reads its generation.
   // The update state finishes the read-modify-write and loads the result register; it
   // waits there only while an earlier result has not yet been taken.
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      idx_in         = idx_ff;
      gen_in         = gen_ff;
      hw_in          = hw_ff;
      live_in        = live_ff;
      alloc_found_in = alloc_found_ff;
      alloc_slot_in  = alloc_slot_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_gen_in     = rsp_gen_ff;
      rsp_live_in    = rsp_live_ff;
      req_ready      = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = search.index;
      wr_en          = 1'b0;
      wr_addr        = alloc_slot_ff;
      wr_data        = '0;
      snap           = 1'b0;
      map_update     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = req_handle_index;
            if (req_valid) begin
               rd_en    = 1'b1;
               snap     = 1'b1;
               cmd_in   = req_cmd;
               idx_in   = req_handle_index;
               gen_in   = req_handle_generation;
               state_in = (req_cmd == CMD_ALLOC) ? ST_SEARCH : ST_UPDATE;
            end
         end

         ST_SEARCH: begin
            rd_en          = 1'b1;
            rd_addr        = search.index;
            alloc_found_in = search.found;
            alloc_slot_in  = search.index;
            state_in       = ST_UPDATE;
         end

         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_index_in  = '0;
               rsp_gen_in    = '0;
               state_in      = ST_IDLE;

               unique case (cmd_ff)
                  CMD_ALLOC: begin
                     if (alloc_found_ff) begin
                        // Reuse a freed slot under the next generation.
                        wr_en               = 1'b1;
                        wr_addr             = alloc_slot_ff;
                        wr_data             = rd_data + GEN_BITS'(1);
                        map_update.valid    = 1'b1;
                        map_update.free_bit = 1'b0;
                        map_update.index    = alloc_slot_ff;
                        live_in             = live_ff + COUNT_BITS'(1);
                        rsp_index_in        = alloc_slot_ff;
                        rsp_gen_in          = rd_data + GEN_BITS'(1);
                     end else if (hw_ff == COUNT_BITS'(SLOT_COUNT)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        // Open a fresh slot at the high-water mark.
                        wr_en               = 1'b1;
                        wr_addr             = hw_ff[INDEX_BITS-1:0];
                        wr_data             = '0;
                        map_update.valid    = 1'b1;
                        map_update.free_bit = 1'b0;
                        map_update.index    = hw_ff[INDEX_BITS-1:0];
                        hw_in               = hw_ff + COUNT_BITS'(1);
                        live_in             = live_ff + COUNT_BITS'(1);
                        rsp_index_in        = hw_ff[INDEX_BITS-1:0];
                     end
                  end

                  CMD_FREE: begin
                     if (!range_ok) begin
                        rsp_status_in = STATUS_RANGE;
                     end else if (!gen_match) begin
                        rsp_status_in = STATUS_STALE;
                     end else begin
                        map_update.valid    = 1'b1;
                        map_update.free_bit = 1'b1;
                        map_update.index    = idx_ff;
                        rsp_index_in        = idx_ff;
                        rsp_gen_in          = gen_ff;
                        if (live_ff != '0) begin
                           live_in = live_ff - COUNT_BITS'(1);
                        end
                        // The last live handle gone empties the pool.
                        if (live_ff <= COUNT_BITS'(1)) begin
                           hw_in = '0;
                        end
                     end
                  end

                  CMD_LOOKUP: begin
                     if (!range_ok) begin
                        rsp_status_in = STATUS_RANGE;
                     end else if (!gen_match) begin
                        rsp_status_in = STATUS_STALE;
                     end else begin
                        rsp_index_in = idx_ff;
                        rsp_gen_in   = rd_data;
                     end
                  end

                  default: begin
                     // Unused command: no state change, plain result.
                  end
               endcase

               rsp_live_in = live_in;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_index      = rsp_index_ff;
   assign rsp_out_generation = rsp_gen_ff;
   assign rsp_live_count     = rsp_live_ff;

   `GHSP_ASSERT(a_live_within_hw, clock, reset, live_ff <= hw_ff, "live count exceeds high-water mark")
   `GHSP_ASSERT(a_empty_pool_reset, clock, reset, (live_ff == '0) |-> (hw_ff == '0), "empty pool kept its high-water mark")
   `GHSP_ASSERT_NEVER(a_hw_overflow, clock, reset, hw_ff > COUNT_BITS'(SLOT_COUNT), "high-water mark beyond capacity")
   `GHSP_ASSERT(a_result_from_update, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE), "result appeared outside the update state")

endmodule

### rtl/ghsp_gen_ram.sv
// Simple dual-port RAM with a registered read port.
module ghsp_gen_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ghsp_free_map.sv
// Free-slot bitmap with a two-stage lowest-free-slot search.
module ghsp_free_map (
   input  logic                                clock,
   input  logic [ghsp_pkg::COUNT_BITS-1:0]     high_water,
   input  logic                                snap,
   input  ghsp_pkg::map_update_type            update,
   input  logic [ghsp_pkg::INDEX_BITS-1:0]     probe_index,
   output logic                                probe_free,
   output ghsp_pkg::search_result_type         search
);
   import ghsp_pkg::*;

   logic [MAP_BITS-1:0]    free_map_ff;
   logic [MAP_BITS-1:0]    candidate;
   logic [GROUP_COUNT-1:0] group_any_ff;
   logic [GROUP_COUNT-1:0] group_any_in;
   logic [OFFSET_BITS-1:0] group_low_ff [GROUP_COUNT];
   logic [OFFSET_BITS-1:0] group_low_in [GROUP_COUNT];

   always_ff @(posedge clock) begin
      if (update.valid) begin
         free_map_ff[update.index] <= update.free_bit;
      end
   end

   // Only slots below the high-water mark take part; bits above it may be stale.
   always_comb begin
      for (int i = 0; i < MAP_BITS; i++) begin
         candidate[i] = free_map_ff[i] && ($unsigned(i) < 32'(high_water));
      end
   end

   // First stage: per group, whether any slot is free and the lowest one.
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         group_any_in[g] = |candidate[g*GROUP_SIZE +: GROUP_SIZE];
         group_low_in[g] = '0;
         for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            if (candidate[g*GROUP_SIZE + j]) begin
               group_low_in[g] = OFFSET_BITS'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (snap) begin
         group_any_ff <= group_any_in;
         group_low_ff <= group_low_in;
      end
   end

   // Second stage: lowest group with a free slot.
   always_comb begin
      search = '0;
      for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
         if (group_any_ff[g]) begin
            search.found = 1'b1;
            search.index = INDEX_BITS'(g * GROUP_SIZE + int'(group_low_ff[g]));
         end
      end
   end

   assign probe_free = free_map_ff[probe_index];

endmodule

### verif/tb_generational_handle_slot_pool.sv
// Self-checking testbench for the generational handle slot pool.
module tb_generational_handle_slot_pool;
   import ghsp_pkg::*;

   // The command encoding leaves one code unused; the pool must answer it harmlessly.
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   // A correct run of about 1700 requests stays well inside this limit even with the slowest
   // stall pattern, the sender gaps and the long hold-off, so it leaves ample headroom.
   localparam int CYCLE_LIMIT  = 200_000;
   // Length of the long receiver hold-off that fills the pool's pipeline.
   localparam int HOLD_CYCLES  = 300;
   // Free and reuse rounds on one slot in the directed part.
   localparam int REUSE_ROUNDS = 24;
   // Random requests to issue after the directed part; the last episode runs on a little.
   localparam int RANDOM_ITEMS = 1500;
   // Mismatch lines beyond this are counted but no longer printed.
   localparam int REPORT_CAP   = 200;

   // One expected response, with fields at the widths of the response ports.
   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [INDEX_BITS-1:0]  index;
      logic [GEN_BITS-1:0]    generation;
      logic [COUNT_BITS-1:0]  live;
   } pool_outcome_type;

   // Shadow copy of the pool. It applies every accepted request to its own slot table
   // and queues the response the pool should give, then checks responses in order.
   class pool_ledger;
      logic [GEN_BITS-1:0] gen_of_slot [SLOT_COUNT];
      bit                  slot_is_free [SLOT_COUNT];
      int                  open_slots;
      int                  live_handles;
      int                  mismatches;
      int                  results_seen;
      pool_outcome_type    pending_outcomes [$];

      function new();
         foreach (gen_of_slot[s]) begin
            gen_of_slot[s]  = '0;
            slot_is_free[s] = 1'b0;
         end
         open_slots   = 0;
         live_handles = 0;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function logic [STATUS_BITS-1:0] handle_status(input logic [INDEX_BITS-1:0] idx,
                                                     input logic [GEN_BITS-1:0] gen);
         if (idx >= open_slots)
            return STATUS_RANGE;
         if (slot_is_free[idx] || gen_of_slot[idx] != gen)
            return STATUS_STALE;
         return STATUS_OK;
      endfunction

      // Applies one accepted request and queues the response it must produce.
      function logic [STATUS_BITS-1:0] apply_request(input logic [CMD_BITS-1:0] cmd,
                                                     input logic [INDEX_BITS-1:0] idx,
                                                     input logic [GEN_BITS-1:0] gen);
         pool_outcome_type o;
         bit               placed;
         o      = '0;
         placed = 1'b0;
         case (cmd)
            CMD_ALLOC: begin
               // Reuse the lowest free slot below the high-water mark first.
               for (int s = 0; s < open_slots; s++) begin
                  if (!placed && slot_is_free[s]) begin
                     slot_is_free[s] = 1'b0;
                     gen_of_slot[s]  = gen_of_slot[s] + GEN_BITS'(1);
                     live_handles++;
                     o.index      = INDEX_BITS'(s);
                     o.generation = gen_of_slot[s];
                     placed       = 1'b1;
                  end
               end
               if (!placed) begin
                  if (open_slots >= SLOT_COUNT) begin
                     o.status = STATUS_FULL;
                  end else begin
                     gen_of_slot[open_slots]  = '0;
                     slot_is_free[open_slots] = 1'b0;
                     o.index = INDEX_BITS'(open_slots);
                     open_slots++;
                     live_handles++;
                  end
               end
            end
            CMD_FREE, CMD_LOOKUP: begin
               o.status = handle_status(idx, gen);
               if (o.status == STATUS_OK) begin
                  o.index      = idx;
                  o.generation = gen_of_slot[idx];
                  if (cmd == CMD_FREE) begin
                     slot_is_free[idx] = 1'b1;
                     if (live_handles > 0)
                        live_handles--;
                     if (live_handles == 0)
                        open_slots = 0;
                  end
               end
            end
            default: ;
         endcase
         o.live = COUNT_BITS'(live_handles);
         pending_outcomes.push_back(o);
         return o.status;
      endfunction

      task report(input string msg);
         if (mismatches < REPORT_CAP)
            $display("%s", msg);
         mismatches++;
      endtask

      task check_result(input logic [STATUS_BITS-1:0] status,
                        input logic [INDEX_BITS-1:0] index,
                        input logic [GEN_BITS-1:0] generation,
                        input logic [COUNT_BITS-1:0] live);
         pool_outcome_type want;
         results_seen++;
         if (pending_outcomes.size() == 0) begin
            report($sformatf("response %0d arrived with no request outstanding",
                             results_seen));
            return;
         end
         want = pending_outcomes.pop_front();
         if (status !== want.status)
            report($sformatf("response %0d status: got %0d, expected %0d",
                             results_seen, status, want.status));
         if (index !== want.index)
            report($sformatf("response %0d index: got %0d, expected %0d",
                             results_seen, index, want.index));
         if (generation !== want.generation)
            report($sformatf("response %0d generation: got %0d, expected %0d",
                             results_seen, generation, want.generation));
         if (live !== want.live)
            report($sformatf("response %0d live count: got %0d, expected %0d",
                             results_seen, live, want.live));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CMD_BITS-1:0]    req_cmd;
   logic [INDEX_BITS-1:0]  req_handle_index;
   logic [GEN_BITS-1:0]    req_handle_generation;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [INDEX_BITS-1:0]  rsp_out_index;
   logic [GEN_BITS-1:0]    rsp_out_generation;
   logic [COUNT_BITS-1:0]  rsp_live_count;

   pool_ledger             ledger;

   // Sender pacing: when gaps are enabled, requests come in bursts separated by idle gaps.
   bit                     gaps_enabled = 1'b0;
   int                     burst_left   = 0;
   int                     random_sent  = 0;
   logic [STATUS_BITS-1:0] last_status;

   // Receiver pacing: a repeating stall pattern of eight steps, plus a one-off hold-off.
   logic [7:0]             stall_pattern = 8'h00;
   logic [2:0]             stall_step    = 3'd0;
   logic                   hold_request  = 1'b0;
   int                     cycle_count   = 0;

   generational_handle_slot_pool uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_handle_index      (req_handle_index),
      .req_handle_generation (req_handle_generation),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_out_index         (rsp_out_index),
      .rsp_out_generation    (rsp_out_generation),
      .rsp_live_count        (rsp_live_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offers one request from a falling edge and holds it until the pool takes it. The
   // shadow pool is updated at the accepting rising edge, so the next request can be
   // chosen from the up-to-date state. Valid is only lowered when a gap is due, which
   // keeps it high across back-to-back requests.
   task automatic offer(input logic [CMD_BITS-1:0] cmd,
                        input logic [INDEX_BITS-1:0] idx,
                        input logic [GEN_BITS-1:0] gen);
      req_valid             = 1'b1;
      req_cmd               = cmd;
      req_handle_index      = idx;
      req_handle_generation = gen;
      do
         @(posedge clock);
      while (!req_ready);
      last_status = ledger.apply_request(cmd, idx, gen);
      @(negedge clock);
      if (gaps_enabled) begin
         if (burst_left == 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Draws one random request. Most are well formed (allocations, or frees and lookups
   // of live handles) so that the pool reaches deep states; the rest are corrupted
   // generations, handles of freed slots, out-of-range indexes and the unused command.
   task automatic random_item(input int alloc_weight, input int free_share);
      int                    roll;
      int                    slot;
      int                    start;
      logic [CMD_BITS-1:0]   cmd;
      logic [INDEX_BITS-1:0] idx;
      logic [GEN_BITS-1:0]   gen;
      roll = $urandom_range(0, 99);
      cmd  = CMD_ALLOC;
      idx  = INDEX_BITS'($urandom);
      gen  = GEN_BITS'($urandom);
      if (roll < 8) begin
         cmd = CMD_BITS'($urandom_range(0, 3));
      end else if (roll >= 8 + alloc_weight) begin
         cmd   = ($urandom_range(0, 99) < free_share) ? CMD_FREE : CMD_LOOKUP;
         slot  = -1;
         start = $urandom_range(0, SLOT_COUNT - 1);
         for (int k = 0; k < ledger.open_slots; k++) begin
            if (slot < 0 && !ledger.slot_is_free[(start + k) % ledger.open_slots])
               slot = (start + k) % ledger.open_slots;
         end
         if (slot >= 0 && $urandom_range(0, 9) != 0) begin
            idx = INDEX_BITS'(slot);
            gen = ledger.gen_of_slot[slot];
            if ($urandom_range(0, 7) == 0)
               gen ^= 16'd1 << $urandom_range(0, GEN_BITS - 1);
         end else if (ledger.open_slots > 0) begin
            // Any opened slot, which is often a freed one holding an old generation.
            idx = INDEX_BITS'($urandom_range(0, ledger.open_slots - 1));
            gen = ledger.gen_of_slot[idx];
         end
      end
      random_sent++;
      offer(cmd, idx, gen);
   endtask

   // Receiver. It follows its stall pattern, and when asked it holds off for a long
   // stretch so that the pool fills up and stops taking requests.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready    = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready  = !stall_pattern[stall_step];
         stall_step = stall_step + 3'd1;
      end
   end

   // Responses are sampled at the rising edge, before the pool updates its outputs.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_result(rsp_status, rsp_out_index, rsp_out_generation, rsp_live_count);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int   episode;
      int   target;
      int   full_seen;
      logic [GEN_BITS-1:0] gen;
      episode               = 0;
      ledger                = new();
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_cmd               = CMD_ALLOC;
      req_handle_index      = '0;
      req_handle_generation = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. An empty pool rejects every handle as out of range, and the
      // unused command is answered with zeros and the current live count.
      stall_pattern = 8'h5A;
      offer(CMD_LOOKUP, 8'd0, 16'd0);
      offer(CMD_FREE, 8'd5, 16'd0);
      offer(CMD_UNUSED, 8'd0, 16'd0);
      // Three fresh slots, then lookups that match, carry a stale generation, or fall
      // just beyond or far beyond the high-water mark.
      offer(CMD_ALLOC, 8'd0, 16'd0);
      offer(CMD_ALLOC, 8'hFF, 16'hFFFF);
      offer(CMD_ALLOC, 8'd0, 16'd0);
      offer(CMD_LOOKUP, 8'd1, 16'd0);
      offer(CMD_LOOKUP, 8'd1, 16'd1);
      offer(CMD_LOOKUP, 8'd3, 16'd0);
      offer(CMD_LOOKUP, 8'hFF, 16'hFFFF);
      // A free, a second free of the same handle, and a lookup of the freed handle.
      offer(CMD_FREE, 8'd1, 16'd0);
      offer(CMD_FREE, 8'd1, 16'd0);
      offer(CMD_LOOKUP, 8'd1, 16'd0);
      // Reuse of the freed slot advances its generation.
      offer(CMD_ALLOC, 8'd0, 16'd0);
      offer(CMD_LOOKUP, 8'd1, 16'd1);
      offer(CMD_FREE, 8'd0, 16'hFFFF);
      offer(CMD_UNUSED, 8'hFF, 16'hFFFF);
      // Freeing the last live handle empties the pool, after which slot 0 is out of
      // range again and reopens with generation zero.
      offer(CMD_FREE, 8'd0, 16'd0);
      offer(CMD_FREE, 8'd1, 16'd1);
      offer(CMD_FREE, 8'd2, 16'd0);
      offer(CMD_LOOKUP, 8'd0, 16'd0);
      offer(CMD_ALLOC, 8'd0, 16'd0);
      offer(CMD_FREE, 8'd0, 16'd0);

      // Repeated reuse. Slot 1 stays live so that the pool never empties while slot 0
      // is freed and reused, each time under the next generation.
      stall_pattern = 8'h00;
      offer(CMD_ALLOC, 8'd0, 16'd0);
      offer(CMD_ALLOC, 8'd0, 16'd0);
      for (int n = 0; n < REUSE_ROUNDS; n++) begin
         gen = ledger.gen_of_slot[0];
         offer(CMD_FREE, 8'd0, gen);
         offer(CMD_ALLOC, 8'd0, 16'd0);
      end
      offer(CMD_LOOKUP, 8'd0, ledger.gen_of_slot[0]);
      offer(CMD_FREE, 8'd0, ledger.gen_of_slot[0]);
      offer(CMD_FREE, 8'd1, 16'd0);

      // Random part, in episodes that each grow the pool towards a target, churn it and
      // drain it back to empty. One episode fills the pool to capacity so that full is
      // reported repeatedly, and one starts with the long receiver hold-off.
      while (random_sent < RANDOM_ITEMS) begin
         gaps_enabled  = ($urandom_range(0, 3) != 0);
         stall_pattern = ($urandom_range(0, 3) == 0) ? 8'h00 : ($urandom & 8'hFE);
         if (episode == 1)
            hold_request = 1'b1;
         if (episode == 3) begin
            full_seen = 0;
            while (full_seen < 6) begin
               random_item(85, 50);
               if (last_status == STATUS_FULL)
                  full_seen++;
            end
            repeat (60) random_item(50, 50);
         end else begin
            target = $urandom_range(1, 24);
            repeat ($urandom_range(30, 90))
               random_item((ledger.live_handles < target) ? 65 : 25, 50);
         end
         while (ledger.live_handles > 0)
            random_item(2, 90);
         episode++;
      end

      // Wait for every outstanding response, then wait on for any stray responses.
      req_valid = 1'b0;
      while (ledger.pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending_outcomes.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/ghsp_pkg.sv
rtl/ghsp_gen_ram.sv
rtl/ghsp_free_map.sv
rtl/generational_handle_slot_pool.sv
verif/tb_generational_handle_slot_pool.sv
